### hdl/partial_reliability_receiver_core_macros.svh
// Assertion macros used by the receiver checker.
`ifndef PARTIAL_RELIABILITY_RECEIVER_CORE_MACROS_SVH
`define PARTIAL_RELIABILITY_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PRR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/prr_pkg.sv
// Types, codes and constants of the partial reliability receiver.
package prr_pkg;

  localparam int unsigned WINDOW_DEF = 128;

  // Connection states
  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_WAIT_SYN  = 2'd1;
  localparam logic [1:0] ST_WAIT_ACK  = 2'd2;
  localparam logic [1:0] ST_CONNECTED = 2'd3;

  // Operations
  localparam logic OP_LISTEN = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PORT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_INIT_SEQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HS_TIMEOUT      = 2'd2;

  localparam logic [15:0] OWN_PORT_RST        = 16'd0;
  localparam logic [31:0] SERVER_INIT_SEQ_RST = 32'd20;
  localparam logic [31:0] HS_TIMEOUT_RST      = 32'd10;

  localparam int unsigned SYN_MARK_BIT   = 7;
  localparam int unsigned PCT_W          = 7;
  localparam int unsigned LOSS_PCT_SCALE = 100;

  typedef struct packed {
    logic        operation;
    logic [15:0] peer_port;
    logic [31:0] pkt_seq_in;
    logic [31:0] pkt_ack_num_in;
    logic        pkt_ack_flag_in;
    logic [7:0]  pkt_syn_byte_in;
    logic [63:0] pkt_timestamp_in;
    logic [31:0] now_us;
  } prr_item_t;

  typedef struct packed {
    logic        send_packet;
    logic        reply_syn;
    logic        reply_ack;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack_num;
    logic [63:0] reply_timestamp;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dst_port;
    logic        deliver_payload;
    logic        loss_accepted;
    logic [1:0]  conn_status;
  } prr_result_t;

  typedef struct packed {
    logic [15:0] own_port;
    logic [31:0] server_init_seq;
    logic [31:0] hs_timeout_us;
  } prr_cfg_t;

  typedef struct packed {
    logic mark;
    logic received;
  } prr_win_cmd_t;

endpackage

### hdl/prr_window.sv
// Receipt window: slot memory, window index and running lost count.
module prr_window import prr_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prr_win_cmd_t       cmd,
  input  logic [PCT_W-1:0]   pct,
  output logic               loss_ok
);

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned LC_W  = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = LC_W + PCT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  logic             mem [WINDOW];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LC_W-1:0]  lost_r, lost_nxt;
  logic             wrapped_r;
  logic             slot_rd_r;
  logic             cur_slot;
  logic [CMP_W-1:0] lost_scaled;
  logic [CMP_W-1:0] pct_scaled;

  // Slots not yet written since reset read as received.
  assign cur_slot = !wrapped_r || slot_rd_r;

  assign lost_scaled = CMP_W'(lost_r) * CMP_W'(LOSS_PCT_SCALE);
  assign pct_scaled  = CMP_W'(pct) * CMP_W'(WINDOW);
  assign loss_ok     = (lost_scaled <= pct_scaled);

  always_comb begin
    idx_nxt  = idx_r;
    lost_nxt = lost_r;
    if (cmd.mark) begin
      idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      if (cur_slot && !cmd.received) begin
        lost_nxt = lost_r + 1'b1;
      end else if (!cur_slot && cmd.received) begin
        lost_nxt = lost_r - 1'b1;
      end
    end
  end

  // Prefetch the slot at the next index; bypass when it is the one written now.
  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      mem[idx_r] <= cmd.received;
    end
    if (cmd.mark && (idx_nxt == idx_r)) begin
      slot_rd_r <= cmd.received;
    end else begin
      slot_rd_r <= mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      lost_r    <= '0;
      wrapped_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      lost_r <= lost_nxt;
      if (cmd.mark && (idx_r == IDX_LAST)) begin
        wrapped_r <= 1'b1;
      end
    end
  end

endmodule

### hdl/prr_ctrl.sv
// Connection state machine and reply builder.
module prr_ctrl import prr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  prr_item_t        item,
  input  prr_cfg_t         cfg,
  input  logic             loss_ok,
  output prr_win_cmd_t     win_cmd,
  output logic [PCT_W-1:0] pct,
  output prr_result_t      res
);

  logic [1:0]       state_r, state_nxt;
  logic             exp_bit_r, exp_bit_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic [31:0]      client_seq_r, client_seq_nxt;
  logic [31:0]      hs_start_r, hs_start_nxt;
  logic [31:0]      client_seq_p1;
  logic [31:0]      server_seq_p1;
  logic [31:0]      elapsed;
  logic             ack_match;
  prr_win_cmd_t     cmd;

  assign client_seq_p1 = client_seq_r + 32'd1;
  assign server_seq_p1 = cfg.server_init_seq + 32'd1;
  assign elapsed       = item.now_us - hs_start_r;
  assign ack_match     = item.pkt_ack_flag_in && (item.pkt_seq_in == client_seq_p1) &&
                         (item.pkt_ack_num_in == server_seq_p1);
  assign pct           = pct_r;

  always_comb begin
    state_nxt      = state_r;
    exp_bit_nxt    = exp_bit_r;
    pct_nxt        = pct_r;
    client_seq_nxt = client_seq_r;
    hs_start_nxt   = hs_start_r;
    cmd            = '0;
    res            = '0;
    if (item.operation == OP_LISTEN) begin
      state_nxt = ST_WAIT_SYN;
    end else begin
      case (state_r)
        ST_CONNECTED: begin
          if (item.pkt_seq_in == {31'd0, exp_bit_r}) begin
            cmd.mark            = 1'b1;
            cmd.received        = 1'b1;
            exp_bit_nxt         = ~exp_bit_r;
            res.deliver_payload = 1'b1;
          end else if (loss_ok) begin
            cmd.mark          = 1'b1;
            cmd.received      = 1'b0;
            exp_bit_nxt       = ~exp_bit_r;
            res.loss_accepted = 1'b1;
          end
          res.send_packet     = 1'b1;
          res.reply_ack       = 1'b1;
          res.reply_ack_num   = {31'd0, exp_bit_nxt};
          res.reply_timestamp = item.pkt_timestamp_in;
          res.reply_src_port  = cfg.own_port;
          res.reply_dst_port  = item.peer_port;
        end
        ST_WAIT_SYN: begin
          if (item.pkt_syn_byte_in[SYN_MARK_BIT]) begin
            pct_nxt             = item.pkt_syn_byte_in[PCT_W-1:0];
            client_seq_nxt      = item.pkt_seq_in;
            hs_start_nxt        = item.now_us;
            state_nxt           = ST_WAIT_ACK;
            res.send_packet     = 1'b1;
            res.reply_syn       = 1'b1;
            res.reply_ack       = 1'b1;
            res.reply_seq       = cfg.server_init_seq;
            res.reply_ack_num   = item.pkt_seq_in + 32'd1;
            res.reply_timestamp = item.pkt_timestamp_in;
            res.reply_src_port  = cfg.own_port;
            res.reply_dst_port  = item.peer_port;
          end
        end
        ST_WAIT_ACK: begin
          if (ack_match) begin
            state_nxt = ST_CONNECTED;
          end else if (elapsed > cfg.hs_timeout_us) begin
            // Handshake abandoned: drop the loss budget and listen again
            hs_start_nxt = '0;
            pct_nxt      = '0;
            state_nxt    = ST_WAIT_SYN;
          end
        end
        default: begin
        end
      endcase
    end
    res.conn_status = state_nxt;
  end

  assign win_cmd.mark     = cmd.mark && fire;
  assign win_cmd.received = cmd.received;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      exp_bit_r    <= 1'b0;
      pct_r        <= '0;
      client_seq_r <= '0;
      hs_start_r   <= '0;
    end else if (fire) begin
      state_r      <= state_nxt;
      exp_bit_r    <= exp_bit_nxt;
      pct_r        <= pct_nxt;
      client_seq_r <= client_seq_nxt;
      hs_start_r   <= hs_start_nxt;
    end
  end

endmodule

### hdl/partial_reliability_receiver_core.sv
// Top level of the partial reliability receiver: beat registers, config and core.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in_     | input     | in_valid / in_ready   | command or packet header, time
//   out_    | output    | out_valid / out_ready | reply header and status
//   cfg_    | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; an accepted beat is
// held in the input register, which feeds the state machine and window logic, which
// land in the output register; the window slot at the next index is prefetched.
// Reset (rst_n low, synchronous) returns to idle with all window slots received.
// A stalled output holds its beat and the input register takes one more.
module partial_reliability_receiver_core import prr_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [15:0]           in_peer_port,
  input  logic [31:0]           in_pkt_seq_in,
  input  logic [31:0]           in_pkt_ack_num_in,
  input  logic                  in_pkt_ack_flag_in,
  input  logic [7:0]            in_pkt_syn_byte_in,
  input  logic [63:0]           in_pkt_timestamp_in,
  input  logic [31:0]           in_now_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_send_packet,
  output logic                  out_reply_syn,
  output logic                  out_reply_ack,
  output logic [31:0]           out_reply_seq,
  output logic [31:0]           out_reply_ack_num,
  output logic [63:0]           out_reply_timestamp,
  output logic [15:0]           out_reply_src_port,
  output logic [15:0]           out_reply_dst_port,
  output logic                  out_deliver_payload,
  output logic                  out_loss_accepted,
  output logic [1:0]            out_conn_status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  prr_cfg_t         cfg_r;
  prr_item_t        item_r;
  logic             in_v_r;
  prr_result_t      res, res_r;
  logic             out_v_r;
  logic             adv;
  logic             loss_ok;
  logic [PCT_W-1:0] pct;
  prr_win_cmd_t     win_cmd;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_port        <= OWN_PORT_RST;
      cfg_r.server_init_seq <= SERVER_INIT_SEQ_RST;
      cfg_r.hs_timeout_us   <= HS_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OWN_PORT:        cfg_r.own_port        <= cfg_wdata[15:0];
        CFG_SERVER_INIT_SEQ: cfg_r.server_init_seq <= cfg_wdata[31:0];
        CFG_HS_TIMEOUT:      cfg_r.hs_timeout_us   <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation        <= in_operation;
      item_r.peer_port        <= in_peer_port;
      item_r.pkt_seq_in       <= in_pkt_seq_in;
      item_r.pkt_ack_num_in   <= in_pkt_ack_num_in;
      item_r.pkt_ack_flag_in  <= in_pkt_ack_flag_in;
      item_r.pkt_syn_byte_in  <= in_pkt_syn_byte_in;
      item_r.pkt_timestamp_in <= in_pkt_timestamp_in;
      item_r.now_us           <= in_now_us;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  prr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .item    (item_r),
    .cfg     (cfg_r),
    .loss_ok (loss_ok),
    .win_cmd (win_cmd),
    .pct     (pct),
    .res     (res)
  );

  prr_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (win_cmd),
    .pct     (pct),
    .loss_ok (loss_ok)
  );

  assign out_valid           = out_v_r;
  assign out_send_packet     = res_r.send_packet;
  assign out_reply_syn       = res_r.reply_syn;
  assign out_reply_ack       = res_r.reply_ack;
  assign out_reply_seq       = res_r.reply_seq;
  assign out_reply_ack_num   = res_r.reply_ack_num;
  assign out_reply_timestamp = res_r.reply_timestamp;
  assign out_reply_src_port  = res_r.reply_src_port;
  assign out_reply_dst_port  = res_r.reply_dst_port;
  assign out_deliver_payload = res_r.deliver_payload;
  assign out_loss_accepted   = res_r.loss_accepted;
  assign out_conn_status     = res_r.conn_status;

endmodule

### hdl/prr_chk.sv
// Port-level checker for the receiver and its bind to the top level.
`include "partial_reliability_receiver_core_macros.svh"

module prr_chk import prr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_send_packet,
  input logic        out_reply_syn,
  input logic        out_reply_ack,
  input logic [31:0] out_reply_seq,
  input logic [31:0] out_reply_ack_num,
  input logic [63:0] out_reply_timestamp,
  input logic [15:0] out_reply_src_port,
  input logic [15:0] out_reply_dst_port,
  input logic        out_deliver_payload,
  input logic        out_loss_accepted,
  input logic [1:0]  out_conn_status
);

  // A beat without a reply carries an all-zero reply.
  `PRR_ASSERT_IMPL(a_no_reply_zero, out_valid && !out_send_packet, !out_reply_syn && !out_reply_ack && (out_reply_seq == 32'd0) && (out_reply_ack_num == 32'd0) && (out_reply_timestamp == 64'd0) && (out_reply_src_port == 16'd0) && (out_reply_dst_port == 16'd0) && !out_deliver_payload && !out_loss_accepted, "reply fields set without a reply")

  // Delivery and tolerated loss only happen on a connected data ACK.
  `PRR_ASSERT_IMPL(a_data_verdict, out_valid && (out_deliver_payload || out_loss_accepted), !(out_deliver_payload && out_loss_accepted) && out_send_packet && !out_reply_syn && (out_conn_status == ST_CONNECTED) && (out_reply_ack_num[31:1] == 31'd0), "bad data packet verdict")

  // A SYN-ACK leaves the connection waiting for the final ACK.
  `PRR_ASSERT_IMPL(a_synack_state, out_valid && out_send_packet && out_reply_syn, out_reply_ack && (out_conn_status == ST_WAIT_ACK) && !out_deliver_payload && !out_loss_accepted, "SYN-ACK in wrong state")

  // A stalled result beat stays valid with its ack number and status held.
  `PRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_reply_ack_num) && $stable(out_conn_status), "stalled result beat dropped")

endmodule

bind partial_reliability_receiver_core prr_chk u_prr_chk (.*);
